### hdl/vertex_normal_displacement_assert.svh
// Assertion helpers for the displacement block
`ifndef VERTEX_NORMAL_DISPLACEMENT_ASSERT_SVH
`define VERTEX_NORMAL_DISPLACEMENT_ASSERT_SVH

`define VND_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define VND_ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

### hdl/vnd_pkg.sv
package vnd_pkg;

  localparam int DW         = 32;
  localparam int SQW        = 64;
  localparam int ISQ_STAGES = 32;
  localparam int DIV_STAGES = 32;
  localparam int PRE_STAGES = 5;
  localparam int MID_STAGES = 2;
  localparam int LAT        = PRE_STAGES + ISQ_STAGES + MID_STAGES + DIV_STAGES + 1;

  localparam logic signed [DW-1:0] DIST_RESET = 32'sd98304;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [2:0][DW-1:0] v;
    logic [2:0][DW-1:0] mn;
    logic [2:0]         ng;
    logic               z;
  } pay_t;

endpackage

### hdl/vnd_isqrt.sv
module vnd_isqrt (
  input  logic                    clk,
  input  logic                    en,
  input  logic [vnd_pkg::SQW-1:0] x_in,
  output logic [vnd_pkg::DW-1:0]  root
);
  import vnd_pkg::*;

  logic [SQW-1:0] x_r [ISQ_STAGES];
  logic [SQW-1:0] r_r [ISQ_STAGES];

  for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stg
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
    logic [SQW-1:0] x_prev, r_prev, t;
    logic [SQW-1:0] x_nxt, r_nxt;

    if (k == 0) begin : g_first
      assign x_prev = x_in;
      assign r_prev = '0;
    end else begin : g_rest
      assign x_prev = x_r[k-1];
      assign r_prev = r_r[k-1];
    end

    always_comb begin
      t = r_prev + BIT;
      if (x_prev >= t) begin
        x_nxt = x_prev - t;
        r_nxt = (r_prev >> 1) + BIT;
      end else begin
        x_nxt = x_prev;
        r_nxt = r_prev >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= x_nxt;
        r_r[k] <= r_nxt;
      end
    end
  end

  assign root = r_r[ISQ_STAGES-1][DW-1:0];

endmodule

### hdl/vnd_div.sv
module vnd_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [vnd_pkg::SQW-1:0] num,
  input  logic [vnd_pkg::DW-1:0]  den,
  output logic [vnd_pkg::DW-1:0]  quo
);
  import vnd_pkg::*;

  logic [DW-1:0] rem_r [DIV_STAGES];
  logic [DW-1:0] bits_r [DIV_STAGES];
  logic [DW-1:0] den_r [DIV_STAGES];
  logic [DW-1:0] q_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
    logic [DW-1:0] rem_p, bits_p, den_p, q_p;
    logic [DW:0]   t;
    logic [DW-1:0] rem_nxt;
    logic          qb;

    if (k == 0) begin : g_first
      assign rem_p  = num[SQW-1:DW];
      assign bits_p = num[DW-1:0];
      assign den_p  = den;
      assign q_p    = '0;
    end else begin : g_rest
      assign rem_p  = rem_r[k-1];
      assign bits_p = bits_r[k-1];
      assign den_p  = den_r[k-1];
      assign q_p    = q_r[k-1];
    end

    always_comb begin
      t  = {rem_p, bits_p[DW-1]};
      qb = (t >= {1'b0, den_p});
      if (qb) begin
        rem_nxt = DW'(t - {1'b0, den_p});
      end else begin
        rem_nxt = t[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        bits_r[k] <= {bits_p[DW-2:0], 1'b0};
        den_r[k]  <= den_p;
        q_r[k]    <= {q_p[DW-2:0], qb};
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

### hdl/vertex_normal_displacement.sv
// Moves each vertex along its unit normal by the programmed distance:
// moved = v + d * n / |n|, all axes signed Q15.16. One vertex per clock is
// accepted while the output is not stalled; each word passes through 72
// register stages, most of them in the 32-stage square root and the three
// 32-stage dividers, one per displacement component. The whole pipeline holds
// while a finished word waits at the output. A zero normal returns the vertex
// with status 1; an axis that overflows clamps with status 2. The distance
// write is accepted only while the pipeline is empty and no vertex is offered.
`include "vertex_normal_displacement_assert.svh"

module vertex_normal_displacement (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // moved_x, moved_y, moved_z, status, zero pad
  output logic [103:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import vnd_pkg::*;

  logic en;
  logic [LAT-1:0] vld_r;

  logic [DW-1:0] dmag_r;
  logic dneg_r;

  pay_t pay1_r, pay2_r, pay3_r, pay4_r, pay5_r;
  logic [4:0] sh2_r;
  logic [SQW-1:0] sq4_r [3];
  logic [SQW-1:0] sum5_r;
  pay_t pa_r [ISQ_STAGES];
  logic [DW-1:0] len;
  logic [SQW-1:0] prod_r [3];
  logic [DW-1:0] len6_r, len7_r;
  pay_t pay6_r, pay7_r;
  logic [SQW-1:0] num7_r [3];
  pay_t pd_r [DIV_STAGES];
  logic [DW-1:0] quo [3];

  logic [2:0][DW-1:0] mv_r;
  logic [1:0] st_r;

  pay_t pay1_nxt;
  pay_t pay3_nxt;
  logic [DW-1:0] peak;
  logic [4:0] msb, sh_nxt;
  logic [2:0][DW-1:0] mv_nxt;
  logic [1:0] st_nxt;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = ~|vld_r && !in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmag_r <= DW'(DIST_RESET);
      dneg_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dmag_r <= cfg_data[DW-1] ? (~cfg_data + 1'b1) : cfg_data;
      dneg_r <= cfg_data[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pay1_nxt.v[i]  = in_tdata[i*DW +: DW];
      pay1_nxt.ng[i] = in_tdata[(i+3)*DW + DW-1];
      pay1_nxt.mn[i] = pay1_nxt.ng[i] ? (~in_tdata[(i+3)*DW +: DW] + 1'b1)
                                      : in_tdata[(i+3)*DW +: DW];
    end
    pay1_nxt.z = (in_tdata[191:96] == '0);
  end

  always_comb begin
    peak = pay1_r.mn[0];
    if (pay1_r.mn[1] > peak) peak = pay1_r.mn[1];
    if (pay1_r.mn[2] > peak) peak = pay1_r.mn[2];
    msb = '0;
    for (int i = 0; i < DW; i++) begin
      if (peak[i]) msb = 5'(i);
    end
    sh_nxt = (msb < 5'd30) ? 5'd30 - msb : 5'd0;
  end

  always_comb begin
    pay3_nxt = pay2_r;
    for (int i = 0; i < 3; i++) begin
      pay3_nxt.mn[i] = pay2_r.mn[i] << sh2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay1_r <= pay1_nxt;
      pay2_r <= pay1_r;
      sh2_r  <= sh_nxt;
      pay3_r <= pay3_nxt;
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= SQW'(pay3_r.mn[i]) * SQW'(pay3_r.mn[i]);
      end
      pay4_r <= pay3_r;
      sum5_r <= sq4_r[0] + sq4_r[1] + sq4_r[2];
      pay5_r <= pay4_r;
      pa_r[0] <= pay5_r;
      for (int k = 1; k < ISQ_STAGES; k++) pa_r[k] <= pa_r[k-1];
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= SQW'(pa_r[ISQ_STAGES-1].mn[i]) * SQW'(dmag_r);
        num7_r[i] <= prod_r[i] + SQW'(len6_r >> 1);
      end
      len6_r <= len;
      pay6_r <= pa_r[ISQ_STAGES-1];
      len7_r <= len6_r;
      pay7_r <= pay6_r;
      pd_r[0] <= pay7_r;
      for (int k = 1; k < DIV_STAGES; k++) pd_r[k] <= pd_r[k-1];
      mv_r <= mv_nxt;
      st_r <= st_nxt;
    end
  end

  vnd_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x_in (sum5_r),
    .root (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    vnd_div u_div (
      .clk (clk),
      .en  (en),
      .num (num7_r[i]),
      .den (len7_r),
      .quo (quo[i])
    );
  end

  always_comb begin
    logic signed [DW+1:0] disp, s;
    pay_t p;
    p      = pd_r[DIV_STAGES-1];
    st_nxt = ST_OK;
    mv_nxt = p.v;
    disp   = '0;
    s      = '0;
    if (p.z) begin
      st_nxt = ST_ZERO;
    end else begin
      for (int i = 0; i < 3; i++) begin
        disp = (p.ng[i] ^ dneg_r) ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
        s    = $signed({{2{p.v[i][DW-1]}}, p.v[i]}) + disp;
        if (s > $signed(34'sh07FFFFFFF)) begin
          mv_nxt[i] = 32'h7FFFFFFF;
          st_nxt    = ST_SAT;
        end else if (s < $signed(-34'sh080000000)) begin
          mv_nxt[i] = 32'h80000000;
          st_nxt    = ST_SAT;
        end else begin
          mv_nxt[i] = s[DW-1:0];
        end
      end
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {6'd0, st_r, mv_r[2], mv_r[1], mv_r[0]};

  `VND_ASSERT_ALWAYS(a_status_code, st_r != 2'd3 || !out_tvalid, "invalid status code")
  `VND_ASSERT_IMPLIES(a_len_range, vld_r[PRE_STAGES+ISQ_STAGES-1] && !pa_r[ISQ_STAGES-1].z,
    len[DW-1] || len[DW-2], "normal length below normalized range")
  `VND_ASSERT_IMPLIES(a_out_hold, out_tvalid && !out_tready,
    ##1 (out_tvalid && $stable(out_tdata)), "output word changed while stalled")

endmodule
